### design/tlm_pkg.sv
// Shared types, constants and helpers for the thermistor level monitor.
// No dependencies; compiled before every other file of the block.
package tlm_pkg;

    localparam int SENSOR_COUNT = 3;
    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 8;
    localparam int LEVEL_BITS   = 3;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int INDEX_BITS   = ADDR_BITS - 2;

    // floor(x/3) by reciprocal multiply; exact for every x below 2**SUM_BITS
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int DIV_SHIFT = SUM_BITS + 2;
    localparam int RECIP_W   = DIV_SHIFT - 1;
    localparam int PROD_BITS = SUM_BITS + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((2 ** DIV_SHIFT + 2) / 3);

    // register indexes (byte address = 4 * index)
    localparam logic [INDEX_BITS-1:0] REG_RECEDING = INDEX_BITS'(0);
    localparam logic [INDEX_BITS-1:0] REG_FILLING  = INDEX_BITS'(1);
    localparam logic [INDEX_BITS-1:0] REG_OPEN     = INDEX_BITS'(2);
    localparam logic [INDEX_BITS-1:0] REG_SENS_EN  = INDEX_BITS'(3);
    localparam logic [INDEX_BITS-1:0] REG_ALARM_EN = INDEX_BITS'(4);
    localparam logic [INDEX_BITS-1:0] REG_SETTLE   = INDEX_BITS'(5);

    localparam logic [SAMPLE_BITS-1:0]  RST_RECEDING = SAMPLE_BITS'(1500);
    localparam logic [SAMPLE_BITS-1:0]  RST_FILLING  = SAMPLE_BITS'(2500);
    localparam logic [SAMPLE_BITS-1:0]  RST_OPEN     = SAMPLE_BITS'(4000);
    localparam logic [SENSOR_COUNT-1:0] RST_SENS_EN  = '1;
    localparam logic [SENSOR_COUNT-1:0] RST_ALARM_EN = '0;
    localparam logic [COUNT_BITS-1:0]   RST_SETTLE   = COUNT_BITS'(10);

    localparam logic [LEVEL_BITS-1:0] LEVEL_FAULT = LEVEL_BITS'(4);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t receding;
        sample_t filling;
        sample_t open;
    } tlm_limits_t;

    typedef struct packed {
        logic wet;
        logic fault;
    } tlm_chan_state_t;

    // thermometer wet pattern to level; any fault overrides
    function automatic logic [LEVEL_BITS-1:0] tlm_level(
        input logic [SENSOR_COUNT-1:0] wet,
        input logic [SENSOR_COUNT-1:0] fault
    );
        logic [LEVEL_BITS-1:0] lvl;
        lvl = '0;
        for (int k = 0; k <= SENSOR_COUNT; k++)
        begin
            if (wet == SENSOR_COUNT'((1 << k) - 1))
            begin
                lvl = LEVEL_BITS'(k);
            end
        end
        if (|fault)
        begin
            lvl = LEVEL_FAULT;
        end
        return lvl;
    endfunction

endpackage

### design/tlm_ifs.sv
// Valid/ready channel interfaces: sample transactions in, report transactions out.
// Depends on tlm_pkg.
interface tlm_in_if import tlm_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_low;
    sample_t sample_mid;
    sample_t sample_high;

    modport source (output valid, output sample_low, output sample_mid,
                    output sample_high, input ready);
    modport sink   (input valid, input sample_low, input sample_mid,
                    input sample_high, output ready);
endinterface

interface tlm_out_if import tlm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    settled;
    logic [LEVEL_BITS-1:0]   tank_level;
    logic [SENSOR_COUNT-1:0] wet_bits;
    logic [SENSOR_COUNT-1:0] fault_bits;
    logic                    empty_fail;
    logic                    refill_fail;
    logic                    fill_fail;

    modport source (output valid, output settled, output tank_level,
                    output wet_bits, output fault_bits, output empty_fail,
                    output refill_fail, output fill_fail, input ready);
    modport sink   (input valid, input settled, input tank_level,
                    input wet_bits, input fault_bits, input empty_fail,
                    input refill_fail, input fill_fail, output ready);
endinterface

### design/tlm_channel.sv
// One thermistor channel: low-pass filter register and hysteresis classifier.
// Depends on tlm_pkg.
module tlm_channel import tlm_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  sample_t         sample,
    input  logic            enable,
    input  tlm_limits_t     limits,
    input  tlm_chan_state_t state_cur,
    output tlm_chan_state_t state_next
);

    sample_t               filtered_reg;
    sample_t               filtered_next;
    logic [SUM_BITS-1:0]   sum;
    logic [PROD_BITS-1:0]  prod;

    // (sample + 2*prev) / 3
    assign sum  = SUM_BITS'(sample) + {1'b0, filtered_reg, 1'b0};
    assign prod = PROD_BITS'(sum) * PROD_BITS'(RECIP3);
    assign filtered_next = prod[DIV_SHIFT +: SAMPLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filtered_reg <= '0;
        end
        else if (advance)
        begin
            filtered_reg <= filtered_next;
        end
    end

    always_comb
    begin
        state_next = state_cur;
        priority if (!enable)
        begin
            state_next = '{wet: 1'b0, fault: 1'b0};
        end
        else if (state_cur.wet && filtered_next < limits.receding)
        begin
            state_next = '{wet: 1'b0, fault: 1'b0};
        end
        else if (!state_cur.wet && filtered_next > limits.filling
                 && filtered_next < limits.open)
        begin
            state_next = '{wet: 1'b1, fault: 1'b0};
        end
        else if (filtered_next > limits.open)
        begin
            state_next = '{wet: 1'b0, fault: 1'b1};
        end
    end

endmodule

### design/thermistor_level_monitor.sv
// Top level of the thermistor liquid-level monitor: APB register file,
// input register, per-channel filter/classifier and result register.
// Depends on tlm_pkg, tlm_ifs and tlm_channel.

// Takes one sample transaction (one 12-bit count per thermistor) per clock
// and returns one report transaction for each, in order, through the input
// and result registers. While reports are taken, the sustained rate is one
// item per cycle, set by the filter feedback loop of each channel (add,
// constant reciprocal multiply for the divide by three, limit compares),
// which closes through the filter register between the input and result
// registers. A stalled report does not stop intake at once: the input
// register still takes one more transaction, and intake stops only while
// both the input and the result register are full. After reset no clearing
// pass is needed; control and filter state reset at once, payload and result
// registers have none. Registers are written through the APB port at byte
// address 4*index and should only be changed while no transaction is in flight.
module thermistor_level_monitor import tlm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    // streams
    tlm_in_if.sink               samples,
    tlm_out_if.source            report
);

    // ---------------- register file ----------------
    sample_t                 receding_reg;
    sample_t                 filling_reg;
    sample_t                 open_reg;
    logic [SENSOR_COUNT-1:0] sens_en_reg;
    logic [SENSOR_COUNT-1:0] alarm_en_reg;
    logic [COUNT_BITS-1:0]   settle_reg;
    logic [INDEX_BITS-1:0]   cfg_index;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receding_reg <= RST_RECEDING;
            filling_reg  <= RST_FILLING;
            open_reg     <= RST_OPEN;
            sens_en_reg  <= RST_SENS_EN;
            alarm_en_reg <= RST_ALARM_EN;
            settle_reg   <= RST_SETTLE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RECEDING: receding_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_FILLING:  filling_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_OPEN:     open_reg     <= pwdata[SAMPLE_BITS-1:0];
                REG_SENS_EN:  sens_en_reg  <= pwdata[SENSOR_COUNT-1:0];
                REG_ALARM_EN: alarm_en_reg <= pwdata[SENSOR_COUNT-1:0];
                REG_SETTLE:   settle_reg   <= pwdata[COUNT_BITS-1:0];
                default:      ; // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_RECEDING: prdata = DATA_BITS'(receding_reg);
            REG_FILLING:  prdata = DATA_BITS'(filling_reg);
            REG_OPEN:     prdata = DATA_BITS'(open_reg);
            REG_SENS_EN:  prdata = DATA_BITS'(sens_en_reg);
            REG_ALARM_EN: prdata = DATA_BITS'(alarm_en_reg);
            REG_SETTLE:   prdata = DATA_BITS'(settle_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- handshake / pipeline control ----------------
    logic    in_valid_reg;
    sample_t in_sample_reg [SENSOR_COUNT];
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;
    logic    take;

    assign out_free      = !out_valid_reg || report.ready;
    assign advance       = in_valid_reg && out_free;   // item moves to result reg
    assign samples.ready = !in_valid_reg || out_free;
    assign take          = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_sample_reg[0] <= samples.sample_low;
            in_sample_reg[1] <= samples.sample_mid;
            in_sample_reg[2] <= samples.sample_high;
        end
    end

    // ---------------- channels ----------------
    tlm_limits_t             limits;
    logic [SENSOR_COUNT-1:0] wet_reg;
    logic [SENSOR_COUNT-1:0] fault_reg;
    logic [SENSOR_COUNT-1:0] wet_next;
    logic [SENSOR_COUNT-1:0] fault_next;

    assign limits = '{receding: receding_reg, filling: filling_reg, open: open_reg};

    for (genvar i = 0; i < SENSOR_COUNT; i++)
    begin : g_chan
        tlm_chan_state_t st_cur;
        tlm_chan_state_t st_next;

        assign st_cur        = '{wet: wet_reg[i], fault: fault_reg[i]};
        assign wet_next[i]   = st_next.wet;
        assign fault_next[i] = st_next.fault;

        tlm_channel u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .sample     (in_sample_reg[i]),
            .enable     (sens_en_reg[i]),
            .limits     (limits),
            .state_cur  (st_cur),
            .state_next (st_next)
        );
    end

    // ---------------- settling, held level and alarms ----------------
    logic [COUNT_BITS-1:0]   items_seen_reg;
    logic [LEVEL_BITS-1:0]   held_level_reg;
    logic [SENSOR_COUNT-1:0] held_alarms_reg;
    logic                    settled_now;
    logic [LEVEL_BITS-1:0]   held_level_next;
    logic [SENSOR_COUNT-1:0] held_alarms_next;

    // counter stops at the settle count, so it never wraps
    assign settled_now      = items_seen_reg >= settle_reg;
    assign held_level_next  = settled_now ? tlm_level(wet_next, fault_next)
                                          : held_level_reg;
    assign held_alarms_next = settled_now ? (alarm_en_reg & fault_next)
                                          : held_alarms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_reg         <= '0;
            fault_reg       <= '0;
            items_seen_reg  <= '0;
            held_level_reg  <= '0;
            held_alarms_reg <= '0;
        end
        else if (advance)
        begin
            wet_reg         <= wet_next;
            fault_reg       <= fault_next;
            held_level_reg  <= held_level_next;
            held_alarms_reg <= held_alarms_next;
            if (!settled_now)
            begin
                items_seen_reg <= items_seen_reg + 1'b1;
            end
        end
    end

    // ---------------- result register ----------------
    logic                    res_settled_reg;
    logic [LEVEL_BITS-1:0]   res_level_reg;
    logic [SENSOR_COUNT-1:0] res_wet_reg;
    logic [SENSOR_COUNT-1:0] res_fault_reg;
    logic [SENSOR_COUNT-1:0] res_alarms_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_settled_reg <= settled_now;
            res_level_reg   <= held_level_next;
            res_wet_reg     <= wet_next;
            res_fault_reg   <= fault_next;
            res_alarms_reg  <= held_alarms_next;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.settled     = res_settled_reg;
    assign report.tank_level  = res_level_reg;
    assign report.wet_bits    = res_wet_reg;
    assign report.fault_bits  = res_fault_reg;
    assign report.empty_fail  = res_alarms_reg[0];
    assign report.refill_fail = res_alarms_reg[1];
    assign report.fill_fail   = res_alarms_reg[2];

endmodule

### design/tlm_checker.sv
// Port-level checks on report transactions of the level monitor, bound to the top.
// Depends on tlm_pkg and thermistor_level_monitor.
module tlm_checker import tlm_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    settled,
    input logic [LEVEL_BITS-1:0]   tank_level,
    input logic [SENSOR_COUNT-1:0] wet_bits,
    input logic [SENSOR_COUNT-1:0] fault_bits,
    input logic                    empty_fail,
    input logic                    refill_fail,
    input logic                    fill_fail
);

    logic [SENSOR_COUNT-1:0] alarms;
    assign alarms = {fill_fail, refill_fail, empty_fail};

    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tank_level)
            && $stable(wet_bits) && $stable(fault_bits) && $stable(alarms))
        else $error("stalled report changed");

    a_wet_fault_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wet_bits & fault_bits) == '0)
        else $error("sensor both wet and faulted");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tank_level <= LEVEL_FAULT)
        else $error("level code out of range");

    a_fault_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && settled |-> ((tank_level == LEVEL_FAULT) == (fault_bits != '0)))
        else $error("fault level does not match fault bits");

    a_alarm_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && settled |-> (alarms & ~fault_bits) == '0)
        else $error("alarm without fault");

endmodule

bind thermistor_level_monitor tlm_checker u_tlm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (report.valid),
    .out_ready   (report.ready),
    .settled     (report.settled),
    .tank_level  (report.tank_level),
    .wet_bits    (report.wet_bits),
    .fault_bits  (report.fault_bits),
    .empty_fail  (report.empty_fail),
    .refill_fail (report.refill_fail),
    .fill_fail   (report.fill_fail)
);

### tb/tb_thermistor_level_monitor.sv
// Self-checking testbench for thermistor_level_monitor: drives sample transactions with
// random gaps and back-pressure, programs the limits over APB and checks every report.
// Depends on tlm_pkg, tlm_ifs and the design files of the block.
`timescale 1ns / 1ps

module tb_thermistor_level_monitor;
    import tlm_pkg::*;

    localparam int          PHASES          = 16;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int unsigned CYCLE_LIMIT     = 2000000;
    // first index past the register file; writes there must be ignored
    localparam logic [INDEX_BITS-1:0] REG_UNMAPPED = REG_SETTLE + 1'b1;
    localparam sample_t SAMPLE_MAX = '1;

    // one report transaction, field for field as it appears on the port
    typedef struct packed {
        logic                    settled;
        logic [LEVEL_BITS-1:0]   tank_level;
        logic [SENSOR_COUNT-1:0] wet_bits;
        logic [SENSOR_COUNT-1:0] fault_bits;
        logic                    empty_fail;
        logic                    refill_fail;
        logic                    fill_fail;
    } report_t;

    // Behavioral copy of the monitor: filter, hysteresis classifier, settle counter
    // and held level/alarms. Every accepted sample transaction pushes the report
    // it must produce; every accepted report is checked against the oldest one.
    class level_report_checker;
        sample_t                 receding;
        sample_t                 filling;
        sample_t                 open_lim;
        logic [SENSOR_COUNT-1:0] sens_en;
        logic [SENSOR_COUNT-1:0] alarm_en;
        logic [COUNT_BITS-1:0]   settle;

        sample_t                 filt [SENSOR_COUNT];
        logic [SENSOR_COUNT-1:0] wet;
        logic [SENSOR_COUNT-1:0] fault;
        logic [COUNT_BITS-1:0]   seen;
        logic [LEVEL_BITS-1:0]   held_lvl;
        logic [SENSOR_COUNT-1:0] held_alarm;

        report_t expected_reports [$];
        int      errors;

        function new();
            receding   = RST_RECEDING;
            filling    = RST_FILLING;
            open_lim   = RST_OPEN;
            sens_en    = RST_SENS_EN;
            alarm_en   = RST_ALARM_EN;
            settle     = RST_SETTLE;
            foreach (filt[ch])
                filt[ch] = '0;
            wet        = '0;
            fault      = '0;
            seen       = '0;
            held_lvl   = '0;
            held_alarm = '0;
            errors     = 0;
        endfunction

        // upper bits of the bus are dropped, unmapped indexes do nothing
        function void write_reg(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
            case (idx)
                REG_RECEDING: receding = data[SAMPLE_BITS-1:0];
                REG_FILLING:  filling  = data[SAMPLE_BITS-1:0];
                REG_OPEN:     open_lim = data[SAMPLE_BITS-1:0];
                REG_SENS_EN:  sens_en  = data[SENSOR_COUNT-1:0];
                REG_ALARM_EN: alarm_en = data[SENSOR_COUNT-1:0];
                REG_SETTLE:   settle   = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // thermometer pattern 0/1/3/7 gives 0..3, anything else 0, a fault wins
        function logic [LEVEL_BITS-1:0] level_code(logic [SENSOR_COUNT-1:0] w,
                                                   logic [SENSOR_COUNT-1:0] f);
            if (|f)
                return LEVEL_FAULT;
            case (w)
                3'b001:  return LEVEL_BITS'(1);
                3'b011:  return LEVEL_BITS'(2);
                3'b111:  return LEVEL_BITS'(3);
                default: return LEVEL_BITS'(0);
            endcase
        endfunction

        function void note_sample(sample_t lo, sample_t mid, sample_t hi);
            sample_t                s [SENSOR_COUNT];
            logic [SAMPLE_BITS+1:0] acc;
            sample_t                f;
            report_t                rep;
            s = '{lo, mid, hi};
            for (int ch = 0; ch < SENSOR_COUNT; ch++)
            begin
                acc = {2'b00, s[ch]} + {1'b0, filt[ch], 1'b0};
                f = sample_t'(acc / 3);
                filt[ch] = f;
                if (sens_en[ch])
                begin
                    // first matching rule wins; no match leaves both bits alone
                    if (wet[ch] && f < receding)
                    begin
                        wet[ch]   = 1'b0;
                        fault[ch] = 1'b0;
                    end
                    else if (!wet[ch] && f > filling && f < open_lim)
                    begin
                        wet[ch]   = 1'b1;
                        fault[ch] = 1'b0;
                    end
                    else if (f > open_lim)
                    begin
                        wet[ch]   = 1'b0;
                        fault[ch] = 1'b1;
                    end
                end
                else
                begin
                    wet[ch]   = 1'b0;
                    fault[ch] = 1'b0;
                end
            end
            rep.settled = (seen >= settle);
            if (rep.settled)
            begin
                held_lvl   = level_code(wet, fault);
                held_alarm = alarm_en & fault;
            end
            else
            begin
                seen = seen + 1'b1;
            end
            rep.tank_level  = held_lvl;
            rep.wet_bits    = wet;
            rep.fault_bits  = fault;
            rep.empty_fail  = held_alarm[0];
            rep.refill_fail = held_alarm[1];
            rep.fill_fail   = held_alarm[2];
            expected_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("report transaction with nothing expected");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("settled",     8'(want.settled),     8'(got.settled));
            compare_field("tank_level",  8'(want.tank_level),  8'(got.tank_level));
            compare_field("wet_bits",    8'(want.wet_bits),    8'(got.wet_bits));
            compare_field("fault_bits",  8'(want.fault_bits),  8'(got.fault_bits));
            compare_field("empty_fail",  8'(want.empty_fail),  8'(got.empty_fail));
            compare_field("refill_fail", 8'(want.refill_fail), 8'(got.refill_fail));
            compare_field("fill_fail",   8'(want.fill_fail),   8'(got.fill_fail));
        endfunction

        function int unsigned outstanding();
            return expected_reports.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    tlm_in_if  samples_ch ();
    tlm_out_if report_ch ();

    thermistor_level_monitor i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_ch),
        .report  (report_ch)
    );

    level_report_checker sb;

    // per-phase switches: a quiet side never idles, giving back-to-back stretches
    bit          src_quiet;
    bit          snk_quiet;
    int unsigned stall_left;
    int unsigned cycle_count;

    // slow per-channel trajectories: each channel sits near a target for a while
    int          aim      [SENSOR_COUNT];
    int unsigned run_left [SENSOR_COUNT];

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // report side back-pressure: ready drops for a random number of cycles
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            report_ch.ready <= 1'b0;
        end
        else
        begin
            report_ch.ready <= 1'b1;
            stall_left = pick_gap(snk_quiet);
        end
    end

    // report monitor: values read here are the ones before the edge
    always @(posedge clk)
    begin
        report_t got;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            got.settled     = report_ch.settled;
            got.tank_level  = report_ch.tank_level;
            got.wet_bits    = report_ch.wet_bits;
            got.fault_bits  = report_ch.fault_bits;
            got.empty_fail  = report_ch.empty_fail;
            got.refill_fail = report_ch.refill_fail;
            got.fill_fail   = report_ch.fill_fail;
            sb.check_report(got);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_thermistor_level_monitor: FAIL");
            $finish;
        end
    end

    // APB write: setup cycle, access cycle; the register takes the value at the
    // edge that ends the access cycle, and the checker follows at that edge
    task automatic reg_write(input logic [INDEX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // write a register, sometimes with junk above its width
    task automatic set_reg(input logic [INDEX_BITS-1:0] idx, input int unsigned value,
                           input int width);
        logic [DATA_BITS-1:0] data;
        data = DATA_BITS'(value);
        if ($urandom_range(0, 3) == 0)
            data = data | ($urandom() << width);
        reg_write(idx, data);
    endtask

    // one sample transaction; noted in the checker once ready reads high after an edge
    task automatic send_sample(input sample_t lo, input sample_t mid, input sample_t hi);
        int unsigned gap;
        gap = pick_gap(src_quiet);
        if (gap != 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid       <= 1'b1;
        samples_ch.sample_low  <= lo;
        samples_ch.sample_mid  <= mid;
        samples_ch.sample_high <= hi;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        sb.note_sample(lo, mid, hi);
    endtask

    // stop the source, then wait until every transaction in flight has produced
    // its report; a further drain wait after that means the block is idle
    task automatic wait_drained();
        samples_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int clamp_sample(int v);
        if (v < 0)
            return 0;
        if (v > int'(SAMPLE_MAX))
            return int'(SAMPLE_MAX);
        return v;
    endfunction

    // new target for one channel, placed relative to the current limits
    function automatic int choose_aim();
        int t;
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(0, sb.receding);
            2, 3: return $urandom_range(sb.receding, sb.filling);
            4, 5: return $urandom_range(sb.filling, sb.open_lim);
            6:    return $urandom_range(sb.open_lim, SAMPLE_MAX);
            7:
            begin
                // right at a limit, where the strict compares matter
                case ($urandom_range(0, 2))
                    0:       t = sb.receding;
                    1:       t = sb.filling;
                    default: t = sb.open_lim;
                endcase
                return clamp_sample(t + int'($urandom_range(0, 4)) - 2);
            end
            8:    return $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
            default: return $urandom_range(0, SAMPLE_MAX);
        endcase
    endfunction

    function automatic sample_t next_sample(int ch);
        if (run_left[ch] == 0)
        begin
            aim[ch]      = choose_aim();
            run_left[ch] = $urandom_range(3, 25);
        end
        run_left[ch] = run_left[ch] - 1;
        return sample_t'(clamp_sample(aim[ch] + int'($urandom_range(0, 2)) - 1));
    endfunction

    // random register settings for one phase, extremes included
    task automatic new_settings();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned t;
        a = $urandom_range(0, SAMPLE_MAX);
        b = $urandom_range(0, SAMPLE_MAX);
        c = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 9))
            0:
            begin
                // limits pinned to the ends of the range
                a = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                b = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                c = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            end
            1: ;    // unordered limits, applied literally
            default:
            begin
                if (a > b) begin t = a; a = b; b = t; end
                if (b > c) begin t = b; b = c; c = t; end
                if (a > b) begin t = a; a = b; b = t; end
            end
        endcase
        set_reg(REG_RECEDING, a, SAMPLE_BITS);
        set_reg(REG_FILLING, b, SAMPLE_BITS);
        set_reg(REG_OPEN, c, SAMPLE_BITS);
        set_reg(REG_SENS_EN, ($urandom_range(0, 9) < 7) ? 7 : $urandom_range(0, 7),
                SENSOR_COUNT);
        set_reg(REG_ALARM_EN, $urandom_range(0, 7), SENSOR_COUNT);
        case ($urandom_range(0, 7))
            0:       set_reg(REG_SETTLE, 0, COUNT_BITS);
            1:       set_reg(REG_SETTLE, 255, COUNT_BITS);
            default: set_reg(REG_SETTLE, $urandom_range(0, 20), COUNT_BITS);
        endcase
        if ($urandom_range(0, 3) == 0)
            reg_write(REG_UNMAPPED + INDEX_BITS'($urandom_range(0, 1)), $urandom());
    endtask

    initial
    begin
        sb = new();
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        samples_ch.valid       = 1'b0;
        samples_ch.sample_low  = '0;
        samples_ch.sample_mid  = '0;
        samples_ch.sample_high = '0;
        report_ch.ready        = 1'b0;
        src_quiet              = 1'b0;
        snk_quiet              = 1'b0;
        stall_left             = 0;
        cycle_count            = 0;
        foreach (aim[ch])
        begin
            aim[ch]      = 0;
            run_left[ch] = 0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset settings: not yet settled, so the held fields stay at zero
        send_sample('0, '0, '0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, '0, 12'd2730);
        send_sample('0, SAMPLE_MAX, 12'd1365);
        wait_drained();

        // tight limits so the filter crosses them in a few transactions
        set_reg(REG_RECEDING, 1000, SAMPLE_BITS);
        set_reg(REG_FILLING, 2000, SAMPLE_BITS);
        set_reg(REG_OPEN, 3000, SAMPLE_BITS);
        set_reg(REG_SENS_EN, 7, SENSOR_COUNT);
        set_reg(REG_ALARM_EN, 7, SENSOR_COUNT);
        set_reg(REG_SETTLE, 0, COUNT_BITS);
        // full scale: dry -> wet -> open-circuit fault on all three, all alarms
        repeat (4) send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        // faulted channels falling through the wet band go wet, and stay wet below filling
        repeat (2) send_sample('0, '0, '0);
        wait_drained();

        // disabled middle sensor clears its bits while its filter keeps running
        set_reg(REG_SENS_EN, 5, SENSOR_COUNT);
        send_sample('0, '0, '0);
        // low channel climbs back through the wet band and stays wet
        repeat (2) send_sample(SAMPLE_MAX, SAMPLE_MAX, '0);
        // then drops under the receding limit and goes dry
        repeat (3) send_sample('0, SAMPLE_MAX, '0);
        wait_drained();

        // --- random part ---
        for (int ph = 0; ph < PHASES; ph++)
        begin
            new_settings();
            src_quiet = ($urandom_range(0, 4) == 0);
            snk_quiet = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(sample_t'($urandom()), sample_t'($urandom()),
                                sample_t'($urandom()));
                else
                    send_sample(next_sample(0), next_sample(1), next_sample(2));
            end
            wait_drained();
        end

        if (sb.errors == 0)
            $display("tb_thermistor_level_monitor: PASS");
        else
            $display("tb_thermistor_level_monitor: FAIL");
        $finish;
    end

endmodule

### files.f
design/tlm_pkg.sv
design/tlm_ifs.sv
design/tlm_channel.sv
design/thermistor_level_monitor.sv
design/tlm_checker.sv
tb/tb_thermistor_level_monitor.sv
